### design/tlts_pkg.sv
// Package for the two-level thread scheduler.
// Holds the shared sizes, slot states, opcodes and event codes.
// No dependencies.
`default_nettype none

package tlts_pkg;

    // Number of thread slots and derived widths.
    localparam int SLOTS = 16;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);

    // Width of the remaining-ticks field and the quantum register.
    localparam int TW = 16;
    localparam int QW = 8;

    // Quantum register value after reset.
    localparam logic [QW-1:0] QUANTUM_RESET = 8'd20;

    // Life-cycle state of one slot.
    typedef enum logic [1:0] {
        SS_FREE  = 2'd0,
        SS_READY = 2'd1,
        SS_RUN   = 2'd2,
        SS_BLOCK = 2'd3
    } slot_state_t;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_CREATE    = 2'd0,
        OP_TICK      = 2'd1,
        OP_DISK_READ = 2'd2,
        OP_DISK_DONE = 2'd3
    } op_t;

    // Event codes reported with every result.
    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_QUEUED    = 4'd1,
        EV_PREEMPTED = 4'd2,
        EV_REFUSED   = 4'd3,
        EV_QUANTUM   = 4'd4,
        EV_FINISHED  = 4'd5,
        EV_BLOCKED   = 4'd6,
        EV_WOKEN     = 4'd7,
        EV_ALL_DONE  = 4'd8
    } event_t;

endpackage

`default_nettype wire

### design/tlts_fifo.sv
// Slot-number queue with a head pointer and a fill count.
// Used for the low-priority ready queue and the blocked queue.
// Depends on tlts_pkg.
`default_nettype none

module tlts_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic [tlts_pkg::SW-1:0] push_data,
    input  wire logic                   pop,
    output logic      [tlts_pkg::SW-1:0] head_data,
    output logic      [tlts_pkg::CW-1:0] count
);

    logic [tlts_pkg::SW-1:0] mem [tlts_pkg::SLOTS];
    logic [tlts_pkg::SW-1:0] head_reg, head_next;
    logic [tlts_pkg::CW-1:0] count_reg, count_next;
    logic [tlts_pkg::SW-1:0] head_data_reg;
    logic [tlts_pkg::SW:0]   tail_sum;
    logic [tlts_pkg::SW-1:0] tail;
    logic                    do_push;
    logic                    do_pop;

    // Tail position is head plus count, wrapped at the slot count.
    always_comb
    begin
        tail_sum = {1'b0, head_reg} + (tlts_pkg::SW+1)'(count_reg);
        if (tail_sum >= (tlts_pkg::SW+1)'(tlts_pkg::SLOTS))
        begin
            tail_sum = tail_sum - (tlts_pkg::SW+1)'(tlts_pkg::SLOTS);
        end
        tail = tail_sum[tlts_pkg::SW-1:0];
    end

    assign do_push = push && (count_reg < tlts_pkg::CW'(tlts_pkg::SLOTS));
    assign do_pop  = pop && (count_reg != '0);

    // Pointer and count update.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (do_pop)
        begin
            if (head_reg == tlts_pkg::SW'(tlts_pkg::SLOTS - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + 1'b1;
            end
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Queue storage: one write port, registered read of the head entry.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail] <= push_data;
        end
        head_data_reg <= mem[head_reg];
    end

    assign head_data = head_data_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

### design/two_level_thread_scheduler.sv
// Two-level thread scheduler: request sequencer, slot table and selection scan.
// Depends on tlts_pkg and tlts_fifo.
`default_nettype none

// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high, and the receiver
// cannot hold it off. A request that needs no new selection is answered
// straight from the execute state. A request that makes the scheduler pick
// the next thread goes on to the scan and pick states: the selection walks
// the slot table one slot per cycle through the single read port of the
// remaining-ticks memory, comparing each ready high-priority slot against the
// best so far in one shared comparator. busy stays high until the result is out.
module two_level_thread_scheduler (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             opcode,
    input  wire logic                   prio_hi,
    input  wire logic [15:0]            run_ticks,
    input  wire logic                   cache_miss,
    output logic                        done,
    output logic      [3:0]             event_code,
    output logic      [3:0]             running_slot,
    output logic                        running_idle,
    output logic      [3:0]             created_slot,
    input  wire logic                   quantum_we,
    input  wire logic [7:0]             quantum_len
);

    localparam int SW = tlts_pkg::SW;
    localparam int CW = tlts_pkg::CW;
    localparam int TW = tlts_pkg::TW;
    localparam int QW = tlts_pkg::QW;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_PICK = 4'b1000
    } fsm_t;

    fsm_t                   state_reg, state_next;
    tlts_pkg::op_t          op_reg, op_next;
    logic                   hi_reg, hi_next;
    logic [TW-1:0]          ticks_reg, ticks_next;
    logic                   miss_reg, miss_next;
    logic [SW-1:0]          cur_reg, cur_next;
    logic                   run_reg, run_next;
    logic [QW-1:0]          ql_reg, ql_next;
    logic [QW-1:0]          qt_reg;
    tlts_pkg::slot_state_t  status_reg [tlts_pkg::SLOTS];
    tlts_pkg::slot_state_t  status_next [tlts_pkg::SLOTS];
    logic                   high_reg [tlts_pkg::SLOTS];
    logic                   high_next [tlts_pkg::SLOTS];
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   cand_reg, cand_next;
    logic [SW-1:0]          cand_slot_reg, cand_slot_next;
    logic                   best_valid_reg, best_valid_next;
    logic [SW-1:0]          best_slot_reg, best_slot_next;
    logic [TW-1:0]          best_rem_reg, best_rem_next;
    logic                   fin_reg, fin_next;
    tlts_pkg::event_t       ev_reg, ev_next;
    logic [SW-1:0]          created_reg, created_next;
    logic                   done_reg, done_next;

    // Remaining-ticks memory.
    logic [TW-1:0]          rem_mem [tlts_pkg::SLOTS];
    logic [TW-1:0]          rem_rd_reg;
    logic                   rem_we;
    logic [SW-1:0]          rem_waddr;
    logic [TW-1:0]          rem_wdata;
    logic [SW-1:0]          rem_raddr;

    // Queue interfaces.
    logic                   lpush, lpop, bpush, bpop;
    logic [SW-1:0]          lpush_data;
    logic [SW-1:0]          lhead, bhead;
    logic [CW-1:0]          lcount, bcount;

    // Helpers.
    logic                   free_found;
    logic [SW-1:0]          free_slot;
    logic                   high_ready;
    logic [QW-1:0]          quantum_load;
    logic [TW-1:0]          rem_dec;
    logic [QW-1:0]          ql_dec;

    tlts_fifo u_low_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (lpush),
        .push_data (lpush_data),
        .pop       (lpop),
        .head_data (lhead),
        .count     (lcount)
    );

    tlts_fifo u_blk_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bpush),
        .push_data (cur_reg),
        .pop       (bpop),
        .head_data (bhead),
        .count     (bcount)
    );

    // First free slot and any ready high-priority slot.
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        high_ready = 1'b0;
        for (int i = tlts_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == tlts_pkg::SS_FREE)
            begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
            if (status_reg[i] == tlts_pkg::SS_READY && high_reg[i])
            begin
                high_ready = 1'b1;
            end
        end
    end

    // A zero quantum acts as one.
    assign quantum_load = (qt_reg == '0) ? QW'(1) : qt_reg;
    assign rem_dec      = (rem_rd_reg > TW'(1)) ? rem_rd_reg - 1'b1 : '0;
    assign ql_dec       = (ql_reg != '0) ? ql_reg - 1'b1 : '0;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hi_next         = hi_reg;
        ticks_next      = ticks_reg;
        miss_next       = miss_reg;
        cur_next        = cur_reg;
        run_next        = run_reg;
        ql_next         = ql_reg;
        status_next     = status_reg;
        high_next       = high_reg;
        idx_next        = idx_reg;
        cand_next       = cand_reg;
        cand_slot_next  = cand_slot_reg;
        best_valid_next = best_valid_reg;
        best_slot_next  = best_slot_reg;
        best_rem_next   = best_rem_reg;
        fin_next        = fin_reg;
        ev_next         = ev_reg;
        created_next    = created_reg;
        done_next       = 1'b0;
        rem_we          = 1'b0;
        rem_waddr       = cur_reg;
        rem_wdata       = rem_dec;
        rem_raddr       = cur_reg;
        lpush           = 1'b0;
        lpush_data      = cur_reg;
        lpop            = 1'b0;
        bpush           = 1'b0;
        bpop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = tlts_pkg::op_t'(opcode);
                    hi_next    = prio_hi;
                    ticks_next = run_ticks;
                    miss_next  = cache_miss;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                ev_next      = tlts_pkg::EV_NONE;
                created_next = '0;
                fin_next     = 1'b0;
                state_next   = ST_IDLE;
                done_next    = 1'b1;
                case (op_reg)
                    tlts_pkg::OP_CREATE:
                    begin
                        if (!free_found)
                        begin
                            ev_next = tlts_pkg::EV_REFUSED;
                        end
                        else
                        begin
                            status_next[free_slot] = tlts_pkg::SS_READY;
                            high_next[free_slot]   = hi_reg;
                            rem_we       = 1'b1;
                            rem_waddr    = free_slot;
                            rem_wdata    = (ticks_reg == '0) ? TW'(1) : ticks_reg;
                            created_next = free_slot;
                            ev_next      = tlts_pkg::EV_QUEUED;
                            if (!hi_reg)
                            begin
                                lpush      = 1'b1;
                                lpush_data = free_slot;
                                if (!run_reg)
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                            else if (run_reg && !high_reg[cur_reg])
                            begin
                                // High create preempts the running low thread.
                                status_next[cur_reg]   = tlts_pkg::SS_READY;
                                lpush                  = 1'b1;
                                status_next[free_slot] = tlts_pkg::SS_RUN;
                                cur_next = free_slot;
                                ql_next  = quantum_load;
                                ev_next  = tlts_pkg::EV_PREEMPTED;
                            end
                            else if (!run_reg)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end

                    tlts_pkg::OP_TICK:
                    begin
                        if (run_reg)
                        begin
                            rem_we = 1'b1;
                            if (rem_dec == '0)
                            begin
                                status_next[cur_reg] = tlts_pkg::SS_FREE;
                                high_next[cur_reg]   = 1'b0;
                                fin_next   = 1'b1;
                                state_next = ST_SCAN;
                            end
                            else if (!high_reg[cur_reg])
                            begin
                                ql_next = ql_dec;
                                if (high_ready || ql_dec == '0)
                                begin
                                    status_next[cur_reg] = tlts_pkg::SS_READY;
                                    lpush      = 1'b1;
                                    state_next = ST_SCAN;
                                    ev_next    = high_ready ? tlts_pkg::EV_PREEMPTED
                                                            : tlts_pkg::EV_QUANTUM;
                                end
                            end
                        end
                    end

                    tlts_pkg::OP_DISK_READ:
                    begin
                        if (run_reg && miss_reg)
                        begin
                            status_next[cur_reg] = tlts_pkg::SS_BLOCK;
                            bpush      = 1'b1;
                            state_next = ST_SCAN;
                            ev_next    = tlts_pkg::EV_BLOCKED;
                        end
                    end

                    tlts_pkg::OP_DISK_DONE:
                    begin
                        if (bcount != '0)
                        begin
                            bpop = 1'b1;
                            status_next[bhead] = tlts_pkg::SS_READY;
                            if (!high_reg[bhead])
                            begin
                                lpush      = 1'b1;
                                lpush_data = bhead;
                            end
                            if (!run_reg)
                            begin
                                state_next = ST_SCAN;
                            end
                            ev_next = tlts_pkg::EV_WOKEN;
                        end
                    end

                    default:
                    begin
                        ev_next = tlts_pkg::EV_NONE;
                    end
                endcase

                // Enter the selection scan.
                if (state_next == ST_SCAN)
                begin
                    done_next       = 1'b0;
                    idx_next        = '0;
                    cand_next       = 1'b0;
                    best_valid_next = 1'b0;
                end
            end

            ST_SCAN:
            begin
                rem_raddr = idx_reg[SW-1:0];
                // Shared comparator: fewest remaining ticks, lowest slot on ties.
                if (cand_reg && (!best_valid_reg || rem_rd_reg < best_rem_reg))
                begin
                    best_valid_next = 1'b1;
                    best_slot_next  = cand_slot_reg;
                    best_rem_next   = rem_rd_reg;
                end
                if (idx_reg == CW'(tlts_pkg::SLOTS))
                begin
                    cand_next  = 1'b0;
                    state_next = ST_PICK;
                end
                else
                begin
                    cand_next = (status_reg[idx_reg[SW-1:0]] == tlts_pkg::SS_READY)
                                && high_reg[idx_reg[SW-1:0]];
                    cand_slot_next = idx_reg[SW-1:0];
                    idx_next       = idx_reg + 1'b1;
                end
            end

            ST_PICK:
            begin
                // High threads first, then the head of the low ready queue.
                if (best_valid_reg)
                begin
                    status_next[best_slot_reg] = tlts_pkg::SS_RUN;
                    cur_next = best_slot_reg;
                    run_next = 1'b1;
                    ql_next  = quantum_load;
                end
                else if (lcount != '0)
                begin
                    lpop = 1'b1;
                    status_next[lhead] = tlts_pkg::SS_RUN;
                    cur_next = lhead;
                    run_next = 1'b1;
                    ql_next  = quantum_load;
                end
                else
                begin
                    run_next = 1'b0;
                end
                if (fin_reg)
                begin
                    ev_next = (!run_next && bcount == '0) ? tlts_pkg::EV_ALL_DONE
                                                          : tlts_pkg::EV_FINISHED;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_reg        <= 1'b0;
            cur_reg        <= '0;
            ql_reg         <= tlts_pkg::QUANTUM_RESET;
            qt_reg         <= tlts_pkg::QUANTUM_RESET;
            idx_reg        <= '0;
            cand_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            fin_reg        <= 1'b0;
            ev_reg         <= tlts_pkg::EV_NONE;
            created_reg    <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < tlts_pkg::SLOTS; i++)
            begin
                status_reg[i] <= tlts_pkg::SS_FREE;
                high_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            run_reg        <= run_next;
            cur_reg        <= cur_next;
            ql_reg         <= ql_next;
            idx_reg        <= idx_next;
            cand_reg       <= cand_next;
            best_valid_reg <= best_valid_next;
            fin_reg        <= fin_next;
            ev_reg         <= ev_next;
            created_reg    <= created_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            high_reg       <= high_next;
            if (quantum_we)
            begin
                qt_reg <= quantum_len;
            end
        end
    end

    // Request payload and scan data registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        hi_reg        <= hi_next;
        ticks_reg     <= ticks_next;
        miss_reg      <= miss_next;
        cand_slot_reg <= cand_slot_next;
        best_slot_reg <= best_slot_next;
        best_rem_reg  <= best_rem_next;
    end

    // Remaining-ticks memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        rem_rd_reg <= rem_mem[rem_raddr];
    end

    // Outputs.
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign event_code   = ev_reg;
    assign running_slot = run_reg ? 4'(cur_reg) : 4'd0;
    assign running_idle = !run_reg;
    assign created_slot = 4'(created_reg);

    // The result strobe only rises once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // Event codes stay in range.
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> event_code <= 4'd8)
        else $error("event code out of range");

    // Between requests, the running slot is marked as running in the slot table.
    a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && state_reg == ST_IDLE |-> status_reg[cur_reg] == tlts_pkg::SS_RUN)
        else $error("running slot not marked running");

    // The result strobe never stays high: each result is a single pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire
